// File: hdl/qslerp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, fixed-point constants and the arctangent table of the
// quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam int FRAC_BITS = 14;
    localparam int SQ_CELLS  = 31;
    localparam int DIV_CELLS = 46;
    localparam int CORD_W    = 34;
    localparam int ANG_W     = 36;

    localparam logic signed [CORD_W-1:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [ANG_W-1:0]  PI_Q30   = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0]  TWO_PI   = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0]  HALF_PI  = 36'sd1686629713;

    localparam logic REG_NEAR_THRESHOLD = 1'b0;
    localparam logic [24:0] THRESH_RESET = 25'd1678;

    typedef logic signed [16:0] t_comp;

    typedef struct packed {
        logic             linear;
        logic [14:0]      blend;
        t_comp [3:0]      p;
        t_comp [3:0]      q;
        logic [29:0]      c;
        logic [30:0]      s;
    } t_side;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
    } t_cord;

    typedef struct packed {
        logic                 neg;
        logic [30:0]          mag;
        logic [30:0]          rem;
        logic [DIV_CELLS-1:0] quo;
    } t_div;

    typedef struct packed {
        logic [3:0][15:0] comp;
        logic             linear;
    } t_res;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/qslerp_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_sqrt_cell
// One digit of the pipelined integer square root: resolves one root bit.
// ----------------------------------------------------------------------------
module qslerp_sqrt_cell #(
    parameter int BIT = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  qslerp_pkg::t_side   i_side,
    input  logic [60:0]         i_rad,
    input  logic [61:0]         i_root,
    output logic                o_valid,
    output qslerp_pkg::t_side   o_side,
    output logic [60:0]         o_rad,
    output logic [61:0]         o_root
);
    import qslerp_pkg::*;

    localparam logic [61:0] B = 62'd1 << (2 * BIT);

    logic [61:0] trial;
    logic [60:0] n_rad;
    logic [61:0] n_root;
    logic        r_valid;
    t_side       r_side;
    logic [60:0] r_rad;
    logic [61:0] r_root;

    always_comb begin
        trial = i_root + B;
        if ({1'b0, i_rad} >= trial) begin
            n_rad  = i_rad - trial[60:0];
            n_root = (i_root >> 1) + B;
        end else begin
            n_rad  = i_rad;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rad  <= n_rad;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rad   = r_rad;
    assign o_root  = r_root;

endmodule
`default_nettype wire

// File: hdl/qslerp_vec_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_vec_cell
// One CORDIC vectoring micro-rotation: accumulates the angle of (x, y).
// ----------------------------------------------------------------------------
module qslerp_vec_cell #(
    parameter int STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  qslerp_pkg::t_side   i_side,
    input  qslerp_pkg::t_cord   i_cord,
    output logic                o_valid,
    output qslerp_pkg::t_side   o_side,
    output qslerp_pkg::t_cord   o_cord
);
    import qslerp_pkg::*;

    localparam logic signed [CORD_W-1:0] ATAN = $signed({2'b00, atan_q30(STAGE)});

    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    t_cord n_cord;
    t_cord r_cord;
    t_side r_side;
    logic  r_valid;

    always_comb begin
        xs = i_cord.x >>> STAGE;
        ys = i_cord.y >>> STAGE;
        if (i_cord.y >= 0) begin
            n_cord.x = i_cord.x + ys;
            n_cord.y = i_cord.y - xs;
            n_cord.z = i_cord.z + ATAN;
        end else begin
            n_cord.x = i_cord.x - ys;
            n_cord.y = i_cord.y + xs;
            n_cord.z = i_cord.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_cord <= n_cord;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_cord  = r_cord;

endmodule
`default_nettype wire

// File: hdl/qslerp_rot_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_rot_cell
// One CORDIC rotation micro-rotation for both weight angles side by side.
// ----------------------------------------------------------------------------
module qslerp_rot_cell #(
    parameter int STAGE = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  qslerp_pkg::t_side         i_side,
    input  qslerp_pkg::t_cord [1:0]   i_lane,
    output logic                      o_valid,
    output qslerp_pkg::t_side         o_side,
    output qslerp_pkg::t_cord [1:0]   o_lane
);
    import qslerp_pkg::*;

    localparam logic signed [CORD_W-1:0] ATAN = $signed({2'b00, atan_q30(STAGE)});

    logic signed [CORD_W-1:0] xs [2];
    logic signed [CORD_W-1:0] ys [2];
    t_cord [1:0] n_lane;
    t_cord [1:0] r_lane;
    t_side       r_side;
    logic        r_valid;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            xs[k] = i_lane[k].x >>> STAGE;
            ys[k] = i_lane[k].y >>> STAGE;
            if (i_lane[k].z >= 0) begin
                n_lane[k].x = i_lane[k].x - ys[k];
                n_lane[k].y = i_lane[k].y + xs[k];
                n_lane[k].z = i_lane[k].z - ATAN;
            end else begin
                n_lane[k].x = i_lane[k].x + ys[k];
                n_lane[k].y = i_lane[k].y - xs[k];
                n_lane[k].z = i_lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_lane  = r_lane;

endmodule
`default_nettype wire

// File: hdl/qslerp_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_div_cell
// One restoring-division step for both weights: resolves one quotient bit
// of (|sin| << 30) / s.
// ----------------------------------------------------------------------------
module qslerp_div_cell #(
    parameter int BIT = 45
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  qslerp_pkg::t_side        i_side,
    input  qslerp_pkg::t_div [1:0]   i_lane,
    output logic                     o_valid,
    output qslerp_pkg::t_side        o_side,
    output qslerp_pkg::t_div [1:0]   o_lane
);
    import qslerp_pkg::*;

    localparam bit HAS_BIT = (BIT >= 30);
    localparam int MB      = (BIT >= 30) ? (BIT - 30) : 0;

    logic [31:0] trial [2];
    logic [31:0] dvs;
    t_div [1:0]  n_lane;
    t_div [1:0]  r_lane;
    t_side       r_side;
    logic        r_valid;

    always_comb begin
        dvs = {1'b0, i_side.s};
        for (int k = 0; k < 2; k++) begin
            n_lane[k] = i_lane[k];
            trial[k]  = {i_lane[k].rem, (HAS_BIT ? i_lane[k].mag[MB] : 1'b0)};
            if (trial[k] >= dvs) begin
                n_lane[k].rem      = 31'(trial[k] - dvs);
                n_lane[k].quo[BIT] = 1'b1;
            end else begin
                n_lane[k].rem = trial[k][30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_lane  = r_lane;

endmodule
`default_nettype wire

// File: hdl/quaternion_slerp_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_slerp_top
// Pipelined quaternion slerp: dot product, square root, CORDIC angle,
// CORDIC sines, weight division and weighted sum, one pair per cycle while o_ready is high.
//
// Input channel i_valid/o_ready carries a start and an end quaternion and
// the blend factor; output channel o_valid/i_ready carries the four blended
// components and the linear-fallback flag. One beat out per beat in, in order.
// Throughput: one beat per cycle while o_ready is high. Most of the pipeline
// lies in the 31-cell square root, the two CORDIC cell rows and the 46-cell
// divider row.
// The whole pipeline advances together; a two-entry output buffer lets it
// keep accepting while the receiver stalls until both entries are full,
// then o_ready drops and every stage holds.
// Reset (synchronous, active low) empties the pipeline and the output
// buffer and returns near_threshold to 1678. The APB port writes
// near_threshold at address 0; write it only while the block is idle.
// ----------------------------------------------------------------------------
module quaternion_slerp_top #(
    parameter int APPROX_STAGES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_start_x,
    input  logic signed [15:0]  i_start_y,
    input  logic signed [15:0]  i_start_z,
    input  logic signed [15:0]  i_start_w,
    input  logic signed [15:0]  i_end_x,
    input  logic signed [15:0]  i_end_y,
    input  logic signed [15:0]  i_end_z,
    input  logic signed [15:0]  i_end_w,
    input  logic [14:0]         i_blend_factor,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_out_x,
    output logic signed [15:0]  o_out_y,
    output logic signed [15:0]  o_out_z,
    output logic signed [15:0]  o_out_w,
    output logic                o_used_linear
);
    import qslerp_pkg::*;

    localparam int N = APPROX_STAGES;

    logic        en;
    logic [24:0] r_thresh;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_NEAR_THRESHOLD)) begin
            r_thresh <= pwdata[24:0];
        end
    end
    assign prdata = (paddr[2] == REG_NEAR_THRESHOLD) ? {7'd0, r_thresh} : 32'd0;

    // front stages
    logic                r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    t_side               n1_side, r1_side, r2_side, r3_side, n4_side, r4_side;
    t_side               n5_side, r5_side, r6_side, r7_side;
    logic signed [31:0]  r2_prod [4];
    logic signed [33:0]  n3_dot, r3_dot;
    logic                neg4;
    logic [32:0]         n4_dabs, r4_dabs;
    logic signed [34:0]  diff5, rhs5;
    logic [59:0]         r6_c2;
    logic [60:0]         r7_rad;

    always_comb begin
        n1_side        = '0;
        n1_side.blend  = i_blend_factor;
        n1_side.p[0]   = 17'(i_start_x);
        n1_side.p[1]   = 17'(i_start_y);
        n1_side.p[2]   = 17'(i_start_z);
        n1_side.p[3]   = 17'(i_start_w);
        n1_side.q[0]   = 17'(i_end_x);
        n1_side.q[1]   = 17'(i_end_y);
        n1_side.q[2]   = 17'(i_end_z);
        n1_side.q[3]   = 17'(i_end_w);

        n3_dot = 34'(r2_prod[0]) + 34'(r2_prod[1]) + 34'(r2_prod[2]) + 34'(r2_prod[3]);

        neg4    = r3_dot[33];
        n4_dabs = neg4 ? 33'(-r3_dot) : r3_dot[32:0];
        n4_side = r3_side;
        for (int k = 0; k < 4; k++) begin
            n4_side.q[k] = neg4 ? -$signed(r3_side.q[k]) : r3_side.q[k];
        end

        diff5 = 35'sd268435456 - $signed({2'b00, r4_dabs});
        rhs5  = $signed({6'd0, r_thresh, 4'd0});
        n5_side        = r4_side;
        n5_side.linear = !(diff5 > rhs5);
        n5_side.c      = {r4_dabs[27:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid; r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side <= n1_side;
            for (int k = 0; k < 4; k++) begin
                r2_prod[k] <= 32'($signed(r1_side.p[k]) * $signed(r1_side.q[k]));
            end
            r2_side <= r1_side;
            r3_dot  <= n3_dot;
            r3_side <= r2_side;
            r4_dabs <= n4_dabs;
            r4_side <= n4_side;
            r5_side <= n5_side;
            r6_c2   <= r5_side.c * r5_side.c;
            r6_side <= r5_side;
            r7_rad  <= 61'(61'd1 << 60) - {1'b0, r6_c2};
            r7_side <= r6_side;
        end
    end

    // square root cell row
    logic        sq_v    [0:SQ_CELLS];
    t_side       sq_side [0:SQ_CELLS];
    logic [60:0] sq_rad  [0:SQ_CELLS];
    logic [61:0] sq_root [0:SQ_CELLS];

    assign sq_v[0]    = r7_v;
    assign sq_side[0] = r7_side;
    assign sq_rad[0]  = r7_rad;
    assign sq_root[0] = '0;

    for (genvar gi = 0; gi < SQ_CELLS; gi++) begin : g_sqrt
        qslerp_sqrt_cell #(.BIT(SQ_CELLS - 1 - gi)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[gi]),
            .i_side  (sq_side[gi]),
            .i_rad   (sq_rad[gi]),
            .i_root  (sq_root[gi]),
            .o_valid (sq_v[gi+1]),
            .o_side  (sq_side[gi+1]),
            .o_rad   (sq_rad[gi+1]),
            .o_root  (sq_root[gi+1])
        );
    end

    // vectoring cell row
    logic  vc_v    [0:N];
    t_side vc_side [0:N];
    t_cord vc_cord [0:N];

    always_comb begin
        vc_side[0]      = sq_side[SQ_CELLS];
        vc_side[0].s    = sq_root[SQ_CELLS][30:0];
        vc_cord[0].x    = $signed({4'd0, sq_side[SQ_CELLS].c});
        vc_cord[0].y    = $signed({3'd0, sq_root[SQ_CELLS][30:0]});
        vc_cord[0].z    = '0;
    end
    assign vc_v[0] = sq_v[SQ_CELLS];

    for (genvar gv = 0; gv < N; gv++) begin : g_vec
        qslerp_vec_cell #(.STAGE(gv)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vc_v[gv]),
            .i_side  (vc_side[gv]),
            .i_cord  (vc_cord[gv]),
            .o_valid (vc_v[gv+1]),
            .o_side  (vc_side[gv+1]),
            .o_cord  (vc_cord[gv+1])
        );
    end

    // angle scaling and range reduction
    logic                     ra1_v, ra2_v, ra3_v, ra4_v;
    t_side                    ra1_side, ra2_side, ra3_side, ra4_side;
    logic signed [16:0]       one_minus;
    logic signed [50:0]       r_a1_m [2];
    logic signed [50:0]       sh2    [2];
    logic signed [ANG_W-1:0]  n_a2   [2];
    logic signed [ANG_W-1:0]  r_a2   [2];
    logic signed [ANG_W-1:0]  n_a3   [2];
    logic signed [ANG_W-1:0]  r_a3   [2];
    logic signed [ANG_W-1:0]  n_a4   [2];
    logic signed [ANG_W-1:0]  r_a4   [2];

    always_comb begin
        one_minus = 17'sd16384 - $signed({2'b00, vc_side[N].blend});
        for (int k = 0; k < 2; k++) begin
            sh2[k]  = r_a1_m[k] >>> FRAC_BITS;
            n_a2[k] = sh2[k][ANG_W-1:0];
            if (n_a2[k] < 0) begin
                n_a2[k] = n_a2[k] + TWO_PI;
            end
            n_a3[k] = (r_a2[k] > PI_Q30) ? (r_a2[k] - TWO_PI) : r_a2[k];
            if (r_a3[k] > HALF_PI) begin
                n_a4[k] = PI_Q30 - r_a3[k];
            end else if (r_a3[k] < -HALF_PI) begin
                n_a4[k] = -PI_Q30 - r_a3[k];
            end else begin
                n_a4[k] = r_a3[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra1_v <= 1'b0; ra2_v <= 1'b0; ra3_v <= 1'b0; ra4_v <= 1'b0;
        end else if (en) begin
            ra1_v <= vc_v[N]; ra2_v <= ra1_v; ra3_v <= ra2_v; ra4_v <= ra3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1_m[0] <= 51'(one_minus * vc_cord[N].z);
            r_a1_m[1] <= 51'($signed({2'b00, vc_side[N].blend}) * vc_cord[N].z);
            ra1_side  <= vc_side[N];
            r_a2      <= n_a2;
            ra2_side  <= ra1_side;
            r_a3      <= n_a3;
            ra3_side  <= ra2_side;
            r_a4      <= n_a4;
            ra4_side  <= ra3_side;
        end
    end

    // rotation cell row
    logic       rc_v    [0:N];
    t_side      rc_side [0:N];
    t_cord [1:0] rc_lane [0:N];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            rc_lane[0][k].x = GAIN_INV;
            rc_lane[0][k].y = '0;
            rc_lane[0][k].z = r_a4[k][CORD_W-1:0];
        end
    end
    assign rc_v[0]    = ra4_v;
    assign rc_side[0] = ra4_side;

    for (genvar gr = 0; gr < N; gr++) begin : g_rot
        qslerp_rot_cell #(.STAGE(gr)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (rc_v[gr]),
            .i_side  (rc_side[gr]),
            .i_lane  (rc_lane[gr]),
            .o_valid (rc_v[gr+1]),
            .o_side  (rc_side[gr+1]),
            .o_lane  (rc_lane[gr+1])
        );
    end

    // divider cell row
    logic                     rb_v;
    t_side                    rb_side;
    t_div [1:0]               n_b, r_b;
    logic signed [CORD_W-1:0] sin_b [2];
    logic signed [CORD_W-1:0] abs_b [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            sin_b[k]   = rc_lane[N][k].y;
            abs_b[k]   = sin_b[k][CORD_W-1] ? -sin_b[k] : sin_b[k];
            n_b[k].neg = sin_b[k][CORD_W-1];
            n_b[k].mag = abs_b[k][30:0];
            n_b[k].rem = {16'd0, abs_b[k][30:16]};
            n_b[k].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_v <= 1'b0;
        end else if (en) begin
            rb_v <= rc_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b     <= n_b;
            rb_side <= rc_side[N];
        end
    end

    logic       dv_v    [0:DIV_CELLS];
    t_side      dv_side [0:DIV_CELLS];
    t_div [1:0] dv_lane [0:DIV_CELLS];

    assign dv_v[0]    = rb_v;
    assign dv_side[0] = rb_side;
    assign dv_lane[0] = r_b;

    for (genvar gd = 0; gd < DIV_CELLS; gd++) begin : g_div
        qslerp_div_cell #(.BIT(DIV_CELLS - 1 - gd)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[gd]),
            .i_side  (dv_side[gd]),
            .i_lane  (dv_lane[gd]),
            .o_valid (dv_v[gd+1]),
            .o_side  (dv_side[gd+1]),
            .o_lane  (dv_lane[gd+1])
        );
    end

    // weights, products, sums
    logic                rc1_v, rc2_v, rc3_v;
    t_side               rc1_side, rc2_side, rc3_side;
    logic signed [46:0]  n_w [2];
    logic signed [46:0]  r_w [2];
    logic signed [46:0]  quo_s [2];
    logic [30:0]         t30;
    logic signed [63:0]  r_pp [4];
    logic signed [63:0]  r_pq [4];
    logic signed [65:0]  r_sum [4];
    logic signed [35:0]  v_c [4];
    t_res                res;

    always_comb begin
        t30 = {dv_side[DIV_CELLS].blend, 16'd0};
        for (int k = 0; k < 2; k++) begin
            quo_s[k] = $signed({1'b0, dv_lane[DIV_CELLS][k].quo});
        end
        if (dv_side[DIV_CELLS].linear) begin
            n_w[0] = 47'sd1073741824 - $signed({16'd0, t30});
            n_w[1] = $signed({16'd0, t30});
        end else begin
            for (int k = 0; k < 2; k++) begin
                n_w[k] = dv_lane[DIV_CELLS][k].neg ? -quo_s[k] : quo_s[k];
            end
        end
        for (int k = 0; k < 4; k++) begin
            v_c[k] = r_sum[k][65:30];
            if (v_c[k] > 36'sd32767) begin
                res.comp[k] = 16'h7FFF;
            end else if (v_c[k] < -36'sd32768) begin
                res.comp[k] = 16'h8000;
            end else begin
                res.comp[k] = v_c[k][15:0];
            end
        end
        res.linear = rc3_side.linear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc1_v <= 1'b0; rc2_v <= 1'b0; rc3_v <= 1'b0;
        end else if (en) begin
            rc1_v <= dv_v[DIV_CELLS]; rc2_v <= rc1_v; rc3_v <= rc2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w      <= n_w;
            rc1_side <= dv_side[DIV_CELLS];
            for (int k = 0; k < 4; k++) begin
                r_pp[k]  <= 64'(r_w[0] * $signed(rc1_side.p[k]));
                r_pq[k]  <= 64'(r_w[1] * $signed(rc1_side.q[k]));
                r_sum[k] <= 66'(r_pp[k]) + 66'(r_pq[k]) + 66'sd536870912;
            end
            rc2_side <= rc1_side;
            rc3_side <= rc2_side;
        end
    end

    // output buffer
    logic r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    t_res r_out, n_out, r_skid, n_skid;
    logic push, taken;

    assign en    = !r_skid_valid;
    assign push  = en && rc3_v;
    assign taken = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || taken) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = push;
            end
        end else if (push) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready       = en;
    assign o_valid       = r_out_valid;
    assign o_out_x       = r_out.comp[0];
    assign o_out_y       = r_out.comp[1];
    assign o_out_z       = r_out.comp[2];
    assign o_out_w       = r_out.comp[3];
    assign o_used_linear = r_out.linear;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_skid_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !o_ready)
        else $error("input accepted while output buffer full");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready && rc3_v))
        else $error("skid filled without a stalled output and a pipeline beat");

endmodule
`default_nettype wire

// File: tb/sv/qslerp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_checker
// Watches both channels and the register port of the quaternion slerp block,
// computes the blended quaternion for every input beat and compares each
// output beat, field by field, with the oldest pending blend.
// ----------------------------------------------------------------------------
module qslerp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_start_z,
    input  logic signed [15:0] i_start_w,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic signed [15:0] i_end_z,
    input  logic signed [15:0] i_end_w,
    input  logic [14:0]        i_blend_factor,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [15:0] o_out_x,
    input  logic signed [15:0] o_out_y,
    input  logic signed [15:0] o_out_z,
    input  logic signed [15:0] o_out_w,
    input  logic               o_used_linear,
    output int                 o_fail_count,
    output int                 o_pending
);
    import qslerp_pkg::*;

    localparam int STAGES = 16;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    typedef struct {
        logic signed [15:0] comp [4];
        logic               linear;
    } t_blend;

    t_blend      blend_q [$];
    logic [24:0] near_thr;

    function automatic longint floor_shr(input longint v, input int k);
        if (v >= 0) return v >>> k;
        return -(((-v) - 1) >>> k) - 1;
    endfunction

    function automatic longint int_sqrt(input longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(input longint x, input longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(atan_q30(i));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_q30(i));
            end
        end
        return z;
    endfunction

    function automatic longint rotate_sin(input longint a);
        longint x, y, z, xs, ys, pi_v, two_pi;
        pi_v = 64'sd3373259426;
        two_pi = 2 * pi_v;
        x = 64'sd652032874;
        y = 0;
        z = a % two_pi;
        if (z < 0) z += two_pi;
        if (z > pi_v) z -= two_pi;
        if (z > 64'sd1686629713) z = pi_v - z;
        else if (z < -64'sd1686629713) z = -pi_v - z;
        for (int i = 0; i < STAGES; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_q30(i));
            end else begin
                x += ys; y -= xs; z += longint'(atan_q30(i));
            end
        end
        return y;
    endfunction

    function automatic t_blend predict_blend(input longint p[4], input longint q_in[4],
                                             input longint t);
        t_blend r;
        longint q[4];
        longint dot, wp, wq, c, s, w, v;
        dot = 0;
        for (int k = 0; k < 4; k++) begin
            q[k] = q_in[k];
            dot += p[k] * q[k];
        end
        if (dot < 0) begin
            dot = -dot;
            for (int k = 0; k < 4; k++) q[k] = -q[k];
        end
        r.linear = !(((64'sd1 << 28) - dot) > (longint'(near_thr) << 4));
        if (r.linear) begin
            wq = t << 16;
            wp = ONE_Q30 - wq;
        end else begin
            c = dot << 2;
            s = int_sqrt((64'sd1 << 60) - c * c);
            w = vector_angle(c, s);
            wp = (rotate_sin(floor_shr((16384 - t) * w, 14)) * ONE_Q30) / s;
            wq = (rotate_sin(floor_shr(t * w, 14)) * ONE_Q30) / s;
        end
        for (int k = 0; k < 4; k++) begin
            v = floor_shr(wp * p[k] + wq * q[k] + (64'sd1 << 29), 30);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            r.comp[k] = v[15:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        longint p[4], q[4];
        t_blend exp_b;
        logic signed [15:0] got [4];
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            near_thr <= THRESH_RESET;
            blend_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_NEAR_THRESHOLD)
                near_thr <= pwdata[24:0];
            if (i_valid && o_ready) begin
                p = '{i_start_x, i_start_y, i_start_z, i_start_w};
                q = '{i_end_x, i_end_y, i_end_z, i_end_w};
                blend_q.push_back(predict_blend(p, q, longint'(i_blend_factor)));
            end
            if (o_valid && i_ready) begin
                if (blend_q.size() == 0) begin
                    $error("output beat with nothing pending");
                    errs++;
                end else begin
                    exp_b = blend_q.pop_front();
                    got = '{o_out_x, o_out_y, o_out_z, o_out_w};
                    for (int k = 0; k < 4; k++)
                        if (got[k] !== exp_b.comp[k]) begin
                            $error("out_%s: expected %0d, got %0d",
                                   k == 0 ? "x" : k == 1 ? "y" : k == 2 ? "z" : "w",
                                   exp_b.comp[k], got[k]);
                            errs++;
                        end
                    if (o_used_linear !== exp_b.linear) begin
                        $error("used_linear: expected %0d, got %0d",
                               exp_b.linear, o_used_linear);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending <= blend_q.size();
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/tb_quaternion_slerp_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_quaternion_slerp_top
// Drives directed and random quaternion pairs through the slerp block with
// bursty input, stalling output and several threshold settings; the checker
// scores every output beat.
// ----------------------------------------------------------------------------
module tb_quaternion_slerp_top;
    import qslerp_pkg::*;

    logic               i_clk, i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               i_valid, o_ready, o_valid, i_ready, o_used_linear;
    logic signed [15:0] sx, sy, sz, sw, ex, ey, ez, ew;
    logic signed [15:0] o_out_x, o_out_y, o_out_z, o_out_w;
    logic [14:0]        blend;
    int                 fail_count, pending;
    logic               stall_long;

    quaternion_slerp_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_start_x(sx), .i_start_y(sy), .i_start_z(sz), .i_start_w(sw),
        .i_end_x(ex), .i_end_y(ey), .i_end_z(ez), .i_end_w(ew),
        .i_blend_factor(blend),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z), .o_out_w(o_out_w),
        .o_used_linear(o_used_linear)
    );

    qslerp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_start_x(sx), .i_start_y(sy), .i_start_z(sz), .i_start_w(sw),
        .i_end_x(ex), .i_end_y(ey), .i_end_z(ez), .i_end_w(ew),
        .i_blend_factor(blend),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z), .o_out_w(o_out_w),
        .o_used_linear(o_used_linear),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver: random stall pattern, with a long hold-off when requested
    initial begin
        int mode;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_long) begin
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                stall_long = 1'b0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40)) begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(negedge i_clk);
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (160) @(negedge i_clk);
    endtask

    task automatic send_pair(input logic signed [15:0] a[4], input logic signed [15:0] b[4],
                             input logic [14:0] t);
        {sx, sy, sz, sw} <= {a[0], a[1], a[2], a[3]};
        {ex, ey, ez, ew} <= {b[0], b[1], b[2], b[3]};
        blend <= t;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rnd_comp(input int kind);
        case (kind)
            0: return 16'($urandom_range(0, 65535));
            1: return $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
            default: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
        endcase
    endfunction

    // random quaternion pair; the end is sometimes close to or opposite the start
    task automatic rnd_pair(output logic signed [15:0] a[4], output logic signed [15:0] b[4]);
        int kind, d;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++) a[k] = rnd_comp(kind < 7 ? 1 : (kind < 9 ? 0 : 2));
        for (int k = 0; k < 4; k++) begin
            if (kind < 3) begin
                d = $urandom_range(0, 64) - 32;
                b[k] = a[k] + 16'(d);
            end else if (kind == 3) begin
                b[k] = -a[k];
            end else begin
                b[k] = rnd_comp(kind < 7 ? 1 : (kind < 9 ? 0 : 2));
            end
        end
        if (kind < 7) begin
            a[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        end
    endtask

    function automatic logic [14:0] rnd_blend();
        case ($urandom_range(0, 7))
            0: return 15'd0;
            1: return 15'd16384;
            2: return 15'($urandom_range(0, 32767));
            default: return 15'($urandom_range(0, 16384));
        endcase
    endfunction

    initial begin
        logic signed [15:0] a[4], b[4];
        logic [31:0] thr_set[5];
        int sent;
        thr_set = '{32'd0, 32'd1678, 32'd16777216, 32'h01FF_FFFF, 32'd200000};
        stall_long = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        {sx, sy, sz, sw, ex, ey, ez, ew} = '0;
        blend = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed pairs at default threshold
        send_pair('{16'sd16384, 0, 0, 0}, '{16'sd16384, 0, 0, 0}, 15'd8192);
        send_pair('{16'sd16384, 0, 0, 0}, '{0, 16'sd16384, 0, 0}, 15'd8192);
        send_pair('{16'sd16384, 0, 0, 0}, '{0, 16'sd16384, 0, 0}, 15'd0);
        send_pair('{16'sd16384, 0, 0, 0}, '{0, 16'sd16384, 0, 0}, 15'd16384);
        send_pair('{16'sd16384, 0, 0, 0}, '{-16'sd11585, 16'sd11585, 0, 0}, 15'd4096);
        send_pair('{0, 0, 16'sd16384, 0}, '{0, 0, -16'sd16384, 0}, 15'd5000);
        send_pair('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
                  '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 15'd16384);
        send_pair('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
                  '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 15'h7FFF);
        send_pair('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
                  '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 15'd0);
        send_pair('{16'sd11585, 16'sd11585, 0, 0}, '{16'sd11585, 16'sd11000, 0, 16'sd300},
                  15'h7FFF);
        send_pair('{16'sd16384, 0, 0, 0}, '{16'sd16383, 0, 16'sd180, 0}, 15'd9000);
        send_pair('{0, 0, 0, 0}, '{0, 0, 0, 0}, 15'd1234);
        send_pair('{16'sd16384, 0, 0, 0}, '{0, 0, 0, 16'sd16384}, 15'd20000);
        i_valid <= 1'b0;

        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            reg_write(3'd0, thr_set[ph]);
            if (ph == 2) stall_long = 1'b1;
            while (sent < (ph + 1) * 330) begin
                repeat ($urandom_range(1, 30)) begin
                    rnd_pair(a, b);
                    send_pair(a, b, rnd_blend());
                    sent++;
                end
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge i_clk);
                end
            end
            i_valid <= 1'b0;
        end
        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/qslerp_pkg.sv
hdl/qslerp_sqrt_cell.sv
hdl/qslerp_vec_cell.sv
hdl/qslerp_rot_cell.sv
hdl/qslerp_div_cell.sv
hdl/quaternion_slerp_top.sv
tb/sv/qslerp_checker.sv
tb/sv/tb_quaternion_slerp_top.sv
